// File: design/brfr_pkg.sv
`default_nettype none

package brfr_pkg;

    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 11;
    localparam int HDR_BYTES = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_COMMIT  = 3'd4,
        CMD_WR_HDR  = 3'd5,
        CMD_RD_HDR  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_CLIP   = 2'd2,
        ST_SHORT  = 2'd3
    } status_t;

endpackage

`default_nettype wire

// File: design/brfr_req_if.sv
`default_nettype none

interface brfr_req_if
    import brfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  count;

    modport source (output valid, output cmd, output data_byte, output count, input ready);
    modport sink   (input valid, input cmd, input data_byte, input count, output ready);
endinterface

`default_nettype wire

// File: design/brfr_rsp_if.sv
`default_nettype none

interface brfr_rsp_if
    import brfr_pkg::*;
#(
    parameter int ADDR_BITS = 10
)
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    read_byte;
    logic [CNT_W-1:0]     done_count;
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] read_window_offset;
    logic [ADDR_BITS:0]   read_window_len;
    logic [ADDR_BITS-1:0] write_window_offset;
    logic [ADDR_BITS:0]   write_window_len;
    logic [ADDR_BITS:0]   fill_level;
    logic                 is_empty;
    logic                 is_full;

    modport source (
        output valid, output read_byte, output done_count, output status,
        output read_window_offset, output read_window_len,
        output write_window_offset, output write_window_len,
        output fill_level, output is_empty, output is_full,
        input ready
    );
    modport sink (
        input valid, input read_byte, input done_count, input status,
        input read_window_offset, input read_window_len,
        input write_window_offset, input write_window_len,
        input fill_level, input is_empty, input is_full,
        output ready
    );
endinterface

`default_nettype wire

// File: design/brfr_win.sv
`default_nettype none

module brfr_win
#(
    parameter int ADDR_BITS = 10
)
(
    input  wire logic [ADDR_BITS:0]   wptr,
    input  wire logic [ADDR_BITS:0]   rptr,
    output logic      [ADDR_BITS-1:0] rd_off,
    output logic      [ADDR_BITS:0]   rd_len,
    output logic      [ADDR_BITS-1:0] wr_off,
    output logic      [ADDR_BITS:0]   wr_len,
    output logic      [ADDR_BITS:0]   fill,
    output logic                      empty,
    output logic                      full
);
    localparam int PW = ADDR_BITS + 1;
    localparam logic [PW-1:0] Cap = PW'(1 << ADDR_BITS);

    logic [PW-1:0] room;
    logic [PW-1:0] rd_span;
    logic [PW-1:0] wr_span;

    // Free-running pointers: the extra top bit tells full from empty.
    assign fill    = wptr - rptr;
    assign room    = Cap - fill;
    assign rd_off  = rptr[ADDR_BITS-1:0];
    assign wr_off  = wptr[ADDR_BITS-1:0];
    // Bytes left before the wrap point of the array.
    assign rd_span = Cap - PW'(rd_off);
    assign wr_span = Cap - PW'(wr_off);
    assign rd_len  = (fill < rd_span) ? fill : rd_span;
    assign wr_len  = (room < wr_span) ? room : wr_span;
    assign empty   = (fill == '0);
    assign full    = (fill == Cap);
endmodule

`default_nettype wire

// File: design/byte_ring_fifo_with_records_core.sv
`default_nettype none

// Byte ring FIFO of 2**ADDR_BITS bytes with record length headers. Each request on
// req carries one command (push, pop, clear, release, commit, write header, read
// header) and produces exactly one response on rsp, which reports the moved count,
// a status code, the fill level, empty/full and the contiguous read and write
// windows as they stand after the command. All bytes live in one single-port-write,
// single-port-read array with a registered read. Push, pop, clear, release, commit
// and unknown codes go straight from acceptance to the response load; a header write
// first writes its four bytes one per cycle through the write port before the
// response load; a header read issues four reads on the read port, then takes a step
// for the last read's return and the length clip, and then the response load. A new
// request is taken while the previous response still waits in the output register;
// the response step waits only if that register is still occupied and not being
// taken. Commit only advances the write pointer: the bytes in that span are expected
// to have been placed by an outside agent. Reading bytes that were never written
// returns undefined data.
module byte_ring_fifo_with_records_core
    import brfr_pkg::*;
#(
    parameter int ADDR_BITS = 10
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    brfr_req_if.sink    req,
    brfr_rsp_if.source  rsp
);
    localparam int PW    = ADDR_BITS + 1;
    localparam int DEPTH = 1 << ADDR_BITS;
    localparam int EW    = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam logic [PW-1:0] Cap = PW'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,  // wait for a request
        S_HWR  = 5'b00010,  // write the four header bytes
        S_HRD  = 5'b00100,  // issue the four header reads
        S_HRL  = 5'b01000,  // last header byte returns, clip the length
        S_FIN  = 5'b10000   // load the response register
    } state_t;

    state_t             state_reg, state_next;
    logic [PW-1:0]      wptr_reg, wptr_next;
    logic [PW-1:0]      rptr_reg, rptr_next;
    logic [CNT_W-1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    status_t            status_reg, status_next;
    logic               pop_ok_reg, pop_ok_next;
    logic [23:0]        len_lo_reg, len_lo_next;
    logic [PW-1:0]      avail_reg, avail_next;
    logic               out_valid_reg, out_valid_next;

    // Byte array and its registered read port.
    logic [BYTE_W-1:0]  mem [DEPTH];
    logic [BYTE_W-1:0]  rdata_reg;
    logic               wr_en;
    logic [BYTE_W-1:0]  wr_data;
    logic               rd_en;

    // Response payload registers.
    logic [BYTE_W-1:0]    read_byte_reg;
    logic [CNT_W-1:0]     done_count_reg;
    logic [1:0]           status_out_reg;
    logic [ADDR_BITS-1:0] rd_off_reg, wr_off_reg;
    logic [PW-1:0]        rd_len_reg, wr_len_reg, fill_out_reg;
    logic                 empty_reg, full_reg;
    logic                 load_out;

    logic               accept;
    logic [PW-1:0]      fill;
    logic [PW-1:0]      room;
    logic [EW-1:0]      fill_e, room_e, cnt_e;
    logic [31:0]        hdr_len;
    logic               len_clip;

    logic [ADDR_BITS-1:0] w_rd_off, w_wr_off;
    logic [PW-1:0]        w_rd_len, w_wr_len, w_fill;
    logic                 w_empty, w_full;

    // Byte idx of the little-endian header word for a given record length.
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [CNT_W-1:0] cnt,
                                                   input logic [1:0] idx);
        logic [31:0] word;
        begin
            word = 32'(cnt);
            return word[{idx, 3'b000} +: BYTE_W];
        end
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign fill     = wptr_reg - rptr_reg;
    assign room     = Cap - fill;
    assign fill_e   = EW'(fill);
    assign room_e   = EW'(room);
    assign cnt_e    = EW'(req.count);
    assign hdr_len  = {rdata_reg, len_lo_reg};
    assign len_clip = (hdr_len > 32'(avail_reg));

    // Window and level snapshot of the current pointers; only sampled in S_FIN,
    // when the pointers hold their final values for the request.
    brfr_win #(
        .ADDR_BITS (ADDR_BITS)
    ) u_win (
        .wptr   (wptr_reg),
        .rptr   (rptr_reg),
        .rd_off (w_rd_off),
        .rd_len (w_rd_len),
        .wr_off (w_wr_off),
        .wr_len (w_wr_len),
        .fill   (w_fill),
        .empty  (w_empty),
        .full   (w_full)
    );

    always_comb
    begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        idx_next       = idx_reg;
        done_next      = done_reg;
        status_next    = status_reg;
        pop_ok_next    = pop_ok_reg;
        len_lo_next    = len_lo_reg;
        avail_next     = avail_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_data        = req.data_byte;
        rd_en          = 1'b0;
        load_out       = 1'b0;

        // Drop the response once the consumer takes it.
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pop_ok_next = 1'b0;
                    done_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    unique case (cmd_t'(req.cmd))
                        CMD_PUSH:
                        begin
                            if (room == '0)
                            begin
                                status_next = ST_REJECT;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wptr_next = wptr_reg + PW'(1);
                                done_next = CNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (fill == '0)
                            begin
                                status_next = ST_REJECT;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rptr_next   = rptr_reg + PW'(1);
                                done_next   = CNT_W'(1);
                                pop_ok_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            done_next = CNT_W'(fill);
                            rptr_next = wptr_reg;
                        end
                        CMD_RELEASE:
                        begin
                            if (cnt_e > fill_e)
                            begin
                                rptr_next   = rptr_reg + fill;
                                done_next   = CNT_W'(fill);
                                status_next = ST_CLIP;
                            end
                            else
                            begin
                                rptr_next = rptr_reg + PW'(req.count);
                                done_next = req.count;
                            end
                        end
                        CMD_COMMIT:
                        begin
                            if (cnt_e > room_e)
                            begin
                                wptr_next   = wptr_reg + room;
                                done_next   = CNT_W'(room);
                                status_next = ST_CLIP;
                            end
                            else
                            begin
                                wptr_next = wptr_reg + PW'(req.count);
                                done_next = req.count;
                            end
                        end
                        CMD_WR_HDR:
                        begin
                            if (room_e < cnt_e + EW'(HDR_BYTES))
                            begin
                                status_next = ST_REJECT;
                            end
                            else
                            begin
                                hdr_cnt_next = req.count;
                                done_next    = req.count;
                                idx_next     = '0;
                                state_next   = S_HWR;
                            end
                        end
                        CMD_RD_HDR:
                        begin
                            if (fill <= PW'(HDR_BYTES))
                            begin
                                status_next = ST_REJECT;
                            end
                            else
                            begin
                                avail_next = fill - PW'(HDR_BYTES);
                                idx_next   = '0;
                                state_next = S_HRD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_HWR:
            begin
                wr_en     = 1'b1;
                wr_data   = hdr_byte(hdr_cnt_reg, idx_reg);
                wptr_next = wptr_reg + PW'(1);
                idx_next  = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = S_FIN;
                end
            end
            S_HRD:
            begin
                // Read data comes from the registered read port and trails its address.
                rd_en     = 1'b1;
                rptr_next = rptr_reg + PW'(1);
                idx_next  = idx_reg + 2'd1;
                case (idx_reg)
                    2'd1:    len_lo_next[7:0]   = rdata_reg;
                    2'd2:    len_lo_next[15:8]  = rdata_reg;
                    2'd3:    len_lo_next[23:16] = rdata_reg;
                    default: len_lo_next        = len_lo_reg;
                endcase
                if (idx_reg == 2'd3)
                begin
                    state_next = S_HRL;
                end
            end
            S_HRL:
            begin
                if (len_clip)
                begin
                    done_next   = CNT_W'(avail_reg);
                    status_next = ST_SHORT;
                end
                else
                begin
                    done_next = hdr_len[CNT_W-1:0];
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Hold until the response register is free or being emptied.
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_cnt_reg <= hdr_cnt_next;
        idx_reg     <= idx_next;
        done_reg    <= done_next;
        status_reg  <= status_next;
        pop_ok_reg  <= pop_ok_next;
        len_lo_reg  <= len_lo_next;
        avail_reg   <= avail_next;
    end

    // Byte array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg[ADDR_BITS-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rptr_reg[ADDR_BITS-1:0]];
        end
    end

    // Response register; a popped byte is still held in rdata_reg here.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            read_byte_reg  <= pop_ok_reg ? rdata_reg : '0;
            done_count_reg <= done_reg;
            status_out_reg <= status_reg;
            rd_off_reg     <= w_rd_off;
            rd_len_reg     <= w_rd_len;
            wr_off_reg     <= w_wr_off;
            wr_len_reg     <= w_wr_len;
            fill_out_reg   <= w_fill;
            empty_reg      <= w_empty;
            full_reg       <= w_full;
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.read_byte           = read_byte_reg;
    assign rsp.done_count          = done_count_reg;
    assign rsp.status              = status_out_reg;
    assign rsp.read_window_offset  = rd_off_reg;
    assign rsp.read_window_len     = rd_len_reg;
    assign rsp.write_window_offset = wr_off_reg;
    assign rsp.write_window_len    = wr_len_reg;
    assign rsp.fill_level          = fill_out_reg;
    assign rsp.is_empty            = empty_reg;
    assign rsp.is_full             = full_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= Cap)
        else $error("fill level exceeds capacity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (room != '0))
        else $error("array write while full");

    a_pop_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.cmd == CMD_POP && fill != '0)
            |=> (rptr_reg == $past(rptr_reg) + PW'(1)))
        else $error("pop did not advance read pointer by one");

    a_full_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.cmd == CMD_PUSH && room == '0) |=> $stable(wptr_reg))
        else $error("rejected push moved write pointer");

endmodule

`default_nettype wire
